/* rtl/bfx_pkg.sv */
package bfx_pkg;

	// Machine dimensions.
	localparam int TOP_CELL      = 8;
	localparam int PROGRAM_DEPTH = 256;
	localparam int CELL_W        = $clog2(TOP_CELL + 1);
	localparam int ADDR_W        = $clog2(PROGRAM_DEPTH);
	localparam int PC_W          = $clog2(PROGRAM_DEPTH + 1);
	localparam int STEP_W        = 16;
	localparam int DATA_W        = 8;

	// Program symbols.
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	typedef enum logic [1:0] {
		OPC_LOAD    = 2'd0,
		OPC_RUN     = 2'd1,
		OPC_RESTART = 2'd2,
		OPC_NOP     = 2'd3
	} opc_t;

	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_OUTPUT     = 3'd1,
		ST_NEED_INPUT = 3'd2,
		ST_ENDED      = 3'd3,
		ST_STEP_LIMIT = 3'd4,
		ST_UNMATCHED  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		OP_RIGHT,
		OP_LEFT,
		OP_INC,
		OP_DEC,
		OP_OUT,
		OP_IN,
		OP_OPEN,
		OP_CLOSE,
		OP_NOP
	} op_t;

	typedef enum logic [0:0] {
		CFG_PROGRAM_LENGTH = 1'b0,
		CFG_MAX_STEPS      = 1'b1
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic load;
		logic restart;
		logic rd_scan;
		logic step_inc;
		logic apply;
		logic pc_next;
		logic scan_f_start;
		logic scan_b_start;
		logic scan_adv_f;
		logic scan_adv_b;
		logic jump;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic at_end;
		logic step_limit;
		logic cell_zero;
		logic have_input;
		logic pc_zero;
		logic scan_end;
		logic scan_at_zero;
		logic open_top;
		logic close_top;
	} dp_stat_t;

	function automatic op_t decode_op(input logic [7:0] c);
		op_t op;
		case (c)
			CH_RIGHT: op = OP_RIGHT;
			CH_LEFT:  op = OP_LEFT;
			CH_INC:   op = OP_INC;
			CH_DEC:   op = OP_DEC;
			CH_OUT:   op = OP_OUT;
			CH_IN:    op = OP_IN;
			CH_OPEN:  op = OP_OPEN;
			CH_CLOSE: op = OP_CLOSE;
			default:  op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

/* rtl/bfx_datapath.sv */
module bfx_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bfx_pkg::dp_cmd_t               cmd,
	output bfx_pkg::dp_stat_t              stat,
	input  logic [bfx_pkg::ADDR_W-1:0]     load_address,
	input  logic [bfx_pkg::DATA_W-1:0]     program_char,
	input  logic [bfx_pkg::DATA_W-1:0]     input_value,
	input  logic                           input_valid,
	input  logic [bfx_pkg::PC_W-1:0]       program_length,
	input  logic [bfx_pkg::STEP_W-1:0]     max_steps,
	output logic [bfx_pkg::DATA_W-1:0]     out_byte,
	output logic [bfx_pkg::PC_W-1:0]       pc,
	output logic [bfx_pkg::CELL_W-1:0]     pointer
);

	logic [bfx_pkg::DATA_W-1:0] mem [bfx_pkg::PROGRAM_DEPTH];
	logic [bfx_pkg::DATA_W-1:0] rdata_q;
	logic [bfx_pkg::ADDR_W-1:0] rd_addr;

	logic [bfx_pkg::DATA_W-1:0] cells_q [bfx_pkg::TOP_CELL+1];
	logic [bfx_pkg::CELL_W-1:0] ptr_q;
	logic [bfx_pkg::PC_W-1:0]   pc_q;
	logic [bfx_pkg::STEP_W-1:0] steps_q;
	logic [bfx_pkg::PC_W-1:0]   scan_q;
	logic [bfx_pkg::ADDR_W-1:0] depth_q;
	logic [bfx_pkg::DATA_W-1:0] in_val_q;
	logic                       have_in_q;
	logic [bfx_pkg::DATA_W-1:0] out_byte_q;

	logic [bfx_pkg::PC_W-1:0]   prog_end;
	logic [bfx_pkg::DATA_W-1:0] cell_cur;
	bfx_pkg::op_t               op;

	assign rd_addr  = cmd.rd_scan ? scan_q[bfx_pkg::ADDR_W-1:0] : pc_q[bfx_pkg::ADDR_W-1:0];
	assign prog_end = (program_length > bfx_pkg::PC_W'(bfx_pkg::PROGRAM_DEPTH)) ?
		bfx_pkg::PC_W'(bfx_pkg::PROGRAM_DEPTH) : program_length;
	assign cell_cur = cells_q[ptr_q];
	assign op       = bfx_pkg::decode_op(rdata_q);

	// Program memory: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[load_address] <= program_char;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= bfx_pkg::TOP_CELL; i++) begin
				cells_q[i] <= '0;
			end
			ptr_q      <= '0;
			pc_q       <= '0;
			steps_q    <= '0;
			scan_q     <= '0;
			depth_q    <= '0;
			in_val_q   <= '0;
			have_in_q  <= 1'b0;
			out_byte_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i <= bfx_pkg::TOP_CELL; i++) begin
					cells_q[i] <= '0;
				end
				ptr_q <= '0;
				pc_q  <= '0;
			end
			if (cmd.start) begin
				steps_q    <= '0;
				in_val_q   <= input_value;
				have_in_q  <= input_valid;
				out_byte_q <= '0;
			end
			if (cmd.step_inc) begin
				steps_q <= steps_q + bfx_pkg::STEP_W'(1);
			end
			if (cmd.apply) begin
				case (op)
					bfx_pkg::OP_RIGHT: begin
						if (ptr_q < bfx_pkg::CELL_W'(bfx_pkg::TOP_CELL)) begin
							ptr_q <= ptr_q + bfx_pkg::CELL_W'(1);
						end
					end
					bfx_pkg::OP_LEFT: begin
						if (ptr_q != '0) begin
							ptr_q <= ptr_q - bfx_pkg::CELL_W'(1);
						end
					end
					bfx_pkg::OP_INC: cells_q[ptr_q] <= cell_cur + bfx_pkg::DATA_W'(1);
					bfx_pkg::OP_DEC: cells_q[ptr_q] <= cell_cur - bfx_pkg::DATA_W'(1);
					bfx_pkg::OP_OUT: out_byte_q <= cell_cur;
					bfx_pkg::OP_IN: begin
						cells_q[ptr_q] <= in_val_q;
						have_in_q      <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.pc_next) begin
				pc_q <= pc_q + bfx_pkg::PC_W'(1);
			end
			if (cmd.scan_f_start) begin
				scan_q  <= pc_q + bfx_pkg::PC_W'(1);
				depth_q <= '0;
			end
			if (cmd.scan_b_start) begin
				scan_q  <= pc_q - bfx_pkg::PC_W'(1);
				depth_q <= '0;
			end
			if (cmd.scan_adv_f) begin
				scan_q <= scan_q + bfx_pkg::PC_W'(1);
				if (op == bfx_pkg::OP_OPEN) begin
					depth_q <= depth_q + bfx_pkg::ADDR_W'(1);
				end else if (op == bfx_pkg::OP_CLOSE) begin
					depth_q <= depth_q - bfx_pkg::ADDR_W'(1);
				end
			end
			if (cmd.scan_adv_b) begin
				scan_q <= scan_q - bfx_pkg::PC_W'(1);
				if (op == bfx_pkg::OP_CLOSE) begin
					depth_q <= depth_q + bfx_pkg::ADDR_W'(1);
				end else if (op == bfx_pkg::OP_OPEN) begin
					depth_q <= depth_q - bfx_pkg::ADDR_W'(1);
				end
			end
			if (cmd.jump) begin
				pc_q <= scan_q + bfx_pkg::PC_W'(1);
			end
		end
	end

	always_comb begin
		stat.op           = op;
		stat.at_end       = (pc_q >= prog_end);
		stat.step_limit   = (steps_q >= max_steps);
		stat.cell_zero    = (cell_cur == '0);
		stat.have_input   = have_in_q;
		stat.pc_zero      = (pc_q == '0);
		stat.scan_end     = (scan_q >= prog_end);
		stat.scan_at_zero = (scan_q == '0);
		stat.open_top     = (op == bfx_pkg::OP_OPEN) && (depth_q == '0);
		stat.close_top    = (op == bfx_pkg::OP_CLOSE) && (depth_q == '0);
	end

	assign out_byte = out_byte_q;
	assign pc       = pc_q;
	assign pointer  = ptr_q;

endmodule

/* rtl/bfx_ctrl.sv */
module bfx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        opcode,
	input  logic              out_free,
	input  bfx_pkg::dp_stat_t stat,
	output bfx_pkg::dp_cmd_t  cmd,
	output logic              in_ready,
	output logic              res_push,
	output bfx_pkg::status_t  res_status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_SF_ADDR,
		S_SF_CHK,
		S_SB_ADDR,
		S_SB_CHK,
		S_FINISH
	} state_t;

	state_t           state_q;
	state_t           state_d;
	bfx_pkg::status_t status_q;
	bfx_pkg::status_t status_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		status_d = status_q;
		in_ready = 1'b0;
		res_push = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					status_d  = bfx_pkg::ST_DONE;
					state_d   = S_FINISH;
					case (bfx_pkg::opc_t'(opcode))
						bfx_pkg::OPC_LOAD:    cmd.load    = 1'b1;
						bfx_pkg::OPC_RUN:     state_d     = S_FETCH;
						bfx_pkg::OPC_RESTART: cmd.restart = 1'b1;
						default: ;
					endcase
				end
			end
			S_FETCH: begin
				if (stat.at_end) begin
					status_d = bfx_pkg::ST_ENDED;
					state_d  = S_FINISH;
				end else if (stat.step_limit) begin
					status_d = bfx_pkg::ST_STEP_LIMIT;
					state_d  = S_FINISH;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.step_inc = 1'b1;
				case (stat.op)
					bfx_pkg::OP_OUT: begin
						cmd.apply   = 1'b1;
						cmd.pc_next = 1'b1;
						status_d    = bfx_pkg::ST_OUTPUT;
						state_d     = S_FINISH;
					end
					bfx_pkg::OP_IN: begin
						if (stat.have_input) begin
							cmd.apply   = 1'b1;
							cmd.pc_next = 1'b1;
							state_d     = S_FETCH;
						end else begin
							status_d = bfx_pkg::ST_NEED_INPUT;
							state_d  = S_FINISH;
						end
					end
					bfx_pkg::OP_OPEN: begin
						if (stat.cell_zero) begin
							cmd.scan_f_start = 1'b1;
							state_d          = S_SF_ADDR;
						end else begin
							cmd.pc_next = 1'b1;
							state_d     = S_FETCH;
						end
					end
					bfx_pkg::OP_CLOSE: begin
						if (stat.cell_zero) begin
							cmd.pc_next = 1'b1;
							state_d     = S_FETCH;
						end else if (stat.pc_zero) begin
							status_d = bfx_pkg::ST_UNMATCHED;
							state_d  = S_FINISH;
						end else begin
							cmd.scan_b_start = 1'b1;
							state_d          = S_SB_ADDR;
						end
					end
					default: begin
						cmd.apply   = 1'b1;
						cmd.pc_next = 1'b1;
						state_d     = S_FETCH;
					end
				endcase
			end
			S_SF_ADDR: begin
				cmd.rd_scan = 1'b1;
				if (stat.scan_end) begin
					status_d = bfx_pkg::ST_UNMATCHED;
					state_d  = S_FINISH;
				end else begin
					state_d = S_SF_CHK;
				end
			end
			S_SF_CHK: begin
				if (stat.close_top) begin
					cmd.jump = 1'b1;
					state_d  = S_FETCH;
				end else begin
					cmd.scan_adv_f = 1'b1;
					state_d        = S_SF_ADDR;
				end
			end
			S_SB_ADDR: begin
				cmd.rd_scan = 1'b1;
				state_d     = S_SB_CHK;
			end
			S_SB_CHK: begin
				if (stat.open_top) begin
					cmd.jump = 1'b1;
					state_d  = S_FETCH;
				end else if (stat.scan_at_zero) begin
					status_d = bfx_pkg::ST_UNMATCHED;
					state_d  = S_FINISH;
				end else begin
					cmd.scan_adv_b = 1'b1;
					state_d        = S_SB_ADDR;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					res_push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= bfx_pkg::ST_DONE;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	assign res_status = status_q;

endmodule

/* rtl/brainfuck_execution_core.sv */
// Tape-program execution core. Programs in the eight-symbol language are
// written byte by byte into a 256-entry program memory by load transactions,
// and run over nine byte cells by run transactions; every input transaction
// returns exactly one result transaction carrying a status, the output byte,
// the program counter and the cell pointer. In a run, each program byte is
// read through the single registered read port of the program memory while
// the program end and the step limit are checked, and is then acted on; the
// bytes read while looking for the partner of a jumping bracket pass through
// the same port. The cells are cleared at reset and by restart transactions;
// the program memory holds no reset value, so only positions that were
// loaded may be run. The configuration registers (program length and step
// limit) should be written only while the core is idle.
module brainfuck_execution_core (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port.
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,

	// Command stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] load_address, [15:8] program_char, [23:16] input_value,
	// [24] input_valid, [31:25] zero
	input  logic [31:0] s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]  s_axis_tuser,

	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte, [16:8] program_counter_now, [20:17] pointer_now,
	// [23:21] zero
	output logic [23:0] m_axis_tdata,
	// [2:0] status
	output logic [2:0]  m_axis_tuser
);

	// Configuration registers. The program length may exceed the memory
	// depth; the datapath clamps it when it computes the end of the program.
	logic [bfx_pkg::PC_W-1:0]   program_length_q;
	logic [bfx_pkg::STEP_W-1:0] max_steps_q;

	bfx_pkg::dp_cmd_t  cmd;
	bfx_pkg::dp_stat_t stat;

	logic                       in_ready;
	logic                       res_push;
	logic                       out_free;
	bfx_pkg::status_t           res_status;
	logic [bfx_pkg::DATA_W-1:0] dp_byte;
	logic [bfx_pkg::PC_W-1:0]   dp_pc;
	logic [bfx_pkg::CELL_W-1:0] dp_ptr;

	// Output register. It lets the controller finish one transaction and
	// take the next command while the previous result still waits.
	logic                       m_valid_q;
	bfx_pkg::status_t           m_status_q;
	logic [bfx_pkg::DATA_W-1:0] m_byte_q;
	logic [bfx_pkg::PC_W-1:0]   m_pc_q;
	logic [bfx_pkg::CELL_W-1:0] m_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_length_q <= '0;
			max_steps_q      <= bfx_pkg::STEP_W'(4096);
		end else if (cfg_we) begin
			case (bfx_pkg::cfg_reg_t'(cfg_index))
				bfx_pkg::CFG_PROGRAM_LENGTH: program_length_q <= cfg_data[bfx_pkg::PC_W-1:0];
				bfx_pkg::CFG_MAX_STEPS:      max_steps_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// The controller sequences fetch, execute and bracket scans; it accepts
	// a command only in its idle state.
	bfx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.opcode     (s_axis_tuser),
		.out_free   (out_free),
		.stat       (stat),
		.cmd        (cmd),
		.in_ready   (in_ready),
		.res_push   (res_push),
		.res_status (res_status)
	);

	// The datapath holds the program memory, the cells, the pointer, the
	// program counter, the step counter and the bracket scan position.
	bfx_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.load_address   (s_axis_tdata[7:0]),
		.program_char   (s_axis_tdata[15:8]),
		.input_value    (s_axis_tdata[23:16]),
		.input_valid    (s_axis_tdata[24]),
		.program_length (program_length_q),
		.max_steps      (max_steps_q),
		.out_byte       (dp_byte),
		.pc             (dp_pc),
		.pointer        (dp_ptr)
	);

	assign s_axis_tready = in_ready;
	assign out_free      = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_push) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			m_status_q <= res_status;
			m_byte_q   <= dp_byte;
			m_pc_q     <= dp_pc;
			m_ptr_q    <= dp_ptr;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, m_ptr_q, m_pc_q, m_byte_q};
	assign m_axis_tuser  = m_status_q;

	// Every command moves the controller out of idle, so a second command
	// can never be taken in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("command accepted while a previous one was still in flight");

	// A result is only loaded into a free or draining output register.
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwrote a pending result transaction");

	// The cell pointer saturates at the top cell.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		dp_ptr <= bfx_pkg::CELL_W'(bfx_pkg::TOP_CELL))
		else $error("cell pointer beyond the top cell");

	// The program counter never passes one beyond the last memory position.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		dp_pc <= bfx_pkg::PC_W'(bfx_pkg::PROGRAM_DEPTH))
		else $error("program counter beyond the program memory");

endmodule
